@@ rtl/core/ppc_pkg.sv @@
// ----------------------------------------------------------------------------
// ppc_pkg: shared types, widths and helpers of the particle/plane collision unit
// Fixed point widths of every pipeline quantity, the register map and the
// rounding, saturation and small-vector helpers used by several stages.
// ----------------------------------------------------------------------------
package ppc_pkg;

   localparam int NRM_W   = 18;            // normal, Q1.16
   localparam int POS_W   = 32;            // position, Q16.16
   localparam int GAIN_W  = 18;            // gains, unsigned Q2.16
   localparam int VEL_W   = POS_W + 1;     // p - p_old
   localparam int PN_W    = NRM_W + POS_W; // n_i * p_i at Q.32
   localparam int VN_W    = NRM_W + VEL_W; // n_i * v_i at Q.32
   localparam int DOT_W   = PN_W + 2;      // sum of three products
   localparam int S_W     = 37;            // s = v.n at Q.16
   localparam int NS_W    = NRM_W + S_W;
   localparam int R_W     = 41;            // reflected velocity at Q.16
   localparam int RN_W    = NRM_W + R_W;
   localparam int T_W     = 45;            // t = r.n at Q.16
   localparam int NT_W    = NRM_W + T_W;
   localparam int RV_W    = 47;            // normal part at Q.16
   localparam int RH_W    = 48;            // tangential part at Q.16
   localparam int RVG_W   = RV_W + GAIN_W + 1;
   localparam int RHG_W   = RH_W + GAIN_W + 1;
   localparam int WIDE_W  = 80;            // working width of the helpers
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int NUM_STAGES = 10;
   localparam int SMALL_LIMIT = 429496;    // 0.0001 at Q.32

   typedef logic signed [NRM_W-1:0] nrm_type;
   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic signed [VEL_W-1:0] vel_type;
   typedef logic signed [S_W-1:0]   s_type;
   typedef logic signed [RV_W-1:0]  rv_type;
   typedef logic signed [RH_W-1:0]  rh_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NORMAL_X     = 3'd0,
      CSR_NORMAL_Y     = 3'd1,
      CSR_NORMAL_Z     = 3'd2,
      CSR_PLANE_OFFSET = 3'd3,
      CSR_FRICTION     = 3'd4,
      CSR_RESTITUTION  = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic signed [NRM_W-1:0] normal_x;
      logic signed [NRM_W-1:0] normal_y;
      logic signed [NRM_W-1:0] normal_z;
      logic signed [POS_W-1:0] plane_offset;
      logic [GAIN_W-1:0]       friction_gain;
      logic [GAIN_W-1:0]       restitution_gain;
   } cfg_type;

   localparam wide_type HALF_LSB = 80'sd32768;
   localparam wide_type POS_MAX  = 80'sh0000_0000_0000_7FFF_FFFF;
   localparam wide_type POS_MIN  = -80'sh0000_0000_0000_8000_0000;

   // round half up, drop 16 fraction bits
   function automatic wide_type rnd16(input wide_type x);
      wide_type y;
      y = x + HALF_LSB;
      return y >>> 16;
   endfunction

   function automatic pos_type sat32(input wide_type x);
      pos_type r;
      if (x > POS_MAX) begin
         r = POS_MAX[POS_W-1:0];
      end else if (x < POS_MIN) begin
         r = POS_MIN[POS_W-1:0];
      end else begin
         r = x[POS_W-1:0];
      end
      return r;
   endfunction

   // squared length at Q.32 at most 0.0001; any component of 1024 or more fails
   function automatic logic is_small(input rh_type c0, input rh_type c1, input rh_type c2);
      rh_type           c [3];
      logic             ok;
      logic [23:0]      sum;
      logic signed [21:0] lo;
      logic signed [21:0] sq;
      c[0] = c0;
      c[1] = c1;
      c[2] = c2;
      ok   = 1'b1;
      sum  = '0;
      for (int i = 0; i < 3; i++) begin
         if (c[i] > 1023 || c[i] < -1023) begin
            ok = 1'b0;
         end
         lo  = c[i][21:0];
         sq  = lo * lo;
         sum = sum + 24'(unsigned'(sq));
      end
      return ok && (sum <= 24'(SMALL_LIMIT));
   endfunction

endpackage

@@ rtl/core/ppc_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppc_pipe_ctrl: valid bits and per-stage load enables
// One valid bit per stage; a stage loads when it is empty or its successor
// loads, so bubbles collapse and a stall loses or repeats nothing.
// ----------------------------------------------------------------------------
module ppc_pipe_ctrl import ppc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  out_ready,
   output logic [NUM_STAGES-1:0] stage_en,
   output logic                  out_valid
);

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;

   always_comb begin
      stage_en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      vld_in[0] = stage_en[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = stage_en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign out_valid = vld_ff[NUM_STAGES-1];

   a_en_chain: assert property (@(posedge clock) disable iff (reset)
      stage_en[NUM_STAGES-1] |-> stage_en[0])
      else $error("load enable of last stage without first stage");
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid)
      else $error("stalled result dropped");
   a_take_beat: assert property (@(posedge clock) disable iff (reset)
      (in_valid && stage_en[0]) |=> vld_ff[0])
      else $error("accepted beat not captured");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

@@ rtl/core/ppc_plane_test.sv @@
// ----------------------------------------------------------------------------
// ppc_plane_test: plane crossing test and velocity projection
// Stage 0 forms n*p, n*p_old and n*v; stage 1 sums them, compares against
// the plane offset and rounds s = v.n to Q.16.
// ----------------------------------------------------------------------------
module ppc_plane_test import ppc_pkg::*; (
   input  logic       clock,
   input  logic [1:0] stage_en,
   input  cfg_type    cfg,
   input  pos_type    pos_in  [3],
   input  pos_type    prev_in [3],
   output logic       hit_out,
   output s_type      s_out,
   output pos_type    pos_out  [3],
   output pos_type    prev_out [3],
   output vel_type    vel_out  [3]
);

   nrm_type nrm [3];
   vel_type vel_in [3];

   logic signed [PN_W-1:0] pn_ff [3];
   logic signed [PN_W-1:0] qn_ff [3];
   logic signed [VN_W-1:0] vn_ff [3];
   pos_type pos0_ff  [3];
   pos_type prev0_ff [3];
   vel_type vel0_ff  [3];

   logic signed [DOT_W-1:0] dp;
   logic signed [DOT_W-1:0] dq;
   logic signed [DOT_W-1:0] dref;
   wide_type                s_sum;

   logic    hit1_ff;
   s_type   s1_ff;
   pos_type pos1_ff  [3];
   pos_type prev1_ff [3];
   vel_type vel1_ff  [3];

   assign nrm[0] = $signed(cfg.normal_x);
   assign nrm[1] = $signed(cfg.normal_y);
   assign nrm[2] = $signed(cfg.normal_z);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vel_in[i] = VEL_W'(pos_in[i]) - VEL_W'(prev_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         for (int i = 0; i < 3; i++) begin
            pn_ff[i]    <= nrm[i] * pos_in[i];
            qn_ff[i]    <= nrm[i] * prev_in[i];
            vn_ff[i]    <= nrm[i] * vel_in[i];
            pos0_ff[i]  <= pos_in[i];
            prev0_ff[i] <= prev_in[i];
            vel0_ff[i]  <= vel_in[i];
         end
      end
   end

   always_comb begin
      dp    = DOT_W'(pn_ff[0]) + DOT_W'(pn_ff[1]) + DOT_W'(pn_ff[2]);
      dq    = DOT_W'(qn_ff[0]) + DOT_W'(qn_ff[1]) + DOT_W'(qn_ff[2]);
      dref  = DOT_W'($signed(cfg.plane_offset)) <<< 16;
      s_sum = WIDE_W'(vn_ff[0]) + WIDE_W'(vn_ff[1]) + WIDE_W'(vn_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         hit1_ff <= (dp < dref) && (dq >= dref);
         s1_ff   <= S_W'(rnd16(s_sum));
         for (int i = 0; i < 3; i++) begin
            pos1_ff[i]  <= pos0_ff[i];
            prev1_ff[i] <= prev0_ff[i];
            vel1_ff[i]  <= vel0_ff[i];
         end
      end
   end

   assign hit_out  = hit1_ff;
   assign s_out    = s1_ff;
   assign pos_out  = pos1_ff;
   assign prev_out = prev1_ff;
   assign vel_out  = vel1_ff;

endmodule

@@ rtl/core/ppc_reflect.sv @@
// ----------------------------------------------------------------------------
// ppc_reflect: velocity reflection and split into normal/tangential parts
// Six stages: n*s, r = v - 2n s, r*n, t = r.n, n*t, then rv, rh, new
// position and the small-part flags.
// ----------------------------------------------------------------------------
module ppc_reflect import ppc_pkg::*; (
   input  logic       clock,
   input  logic [5:0] stage_en,
   input  cfg_type    cfg,
   input  logic       hit_in,
   input  s_type      s_in,
   input  pos_type    pos_in  [3],
   input  pos_type    prev_in [3],
   input  vel_type    vel_in  [3],
   output logic       hit_out,
   output pos_type    np_out   [3],
   output pos_type    prev_out [3],
   output rv_type     rv_out   [3],
   output rh_type     rh_out   [3],
   output logic       rv_small_out,
   output logic       rh_small_out
);

   localparam int NSTG = 6;

   nrm_type nrm [3];

   // pass-through of hit, position and previous position along all stages
   logic    hit_pipe_ff  [NSTG-1];
   pos_type pos_pipe_ff  [NSTG-1][3];
   pos_type prev_pipe_ff [NSTG-1][3];

   vel_type                vel2_ff [3];
   logic signed [NS_W-1:0] ns_ff   [3];
   logic signed [R_W-1:0]  r3_ff   [3];
   logic signed [RN_W-1:0] rn_ff   [3];
   logic signed [R_W-1:0]  r4_ff   [3];
   logic signed [T_W-1:0]  t_ff;
   logic signed [R_W-1:0]  r5_ff   [3];
   logic signed [NT_W-1:0] nt_ff   [3];
   logic signed [R_W-1:0]  r6_ff   [3];

   wide_type t_sum;
   rv_type   rv_c [3];
   rh_type   rh_c [3];
   pos_type  np_c [3];

   logic    hit7_ff;
   pos_type np_ff   [3];
   pos_type prev7_ff [3];
   rv_type  rv_ff   [3];
   rh_type  rh_ff   [3];
   logic    rv_small_ff;
   logic    rh_small_ff;

   assign nrm[0] = $signed(cfg.normal_x);
   assign nrm[1] = $signed(cfg.normal_y);
   assign nrm[2] = $signed(cfg.normal_z);

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG - 1; k++) begin
         if (stage_en[k]) begin
            if (k == 0) begin
               hit_pipe_ff[k]  <= hit_in;
               pos_pipe_ff[k]  <= pos_in;
               prev_pipe_ff[k] <= prev_in;
            end else begin
               hit_pipe_ff[k]  <= hit_pipe_ff[k-1];
               pos_pipe_ff[k]  <= pos_pipe_ff[k-1];
               prev_pipe_ff[k] <= prev_pipe_ff[k-1];
            end
         end
      end
   end

   // stage 2: n*s
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         for (int i = 0; i < 3; i++) begin
            ns_ff[i]   <= nrm[i] * s_in;
            vel2_ff[i] <= vel_in[i];
         end
      end
   end

   // stage 3: r = v - 2 n s, rounded to Q.16
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int i = 0; i < 3; i++) begin
            r3_ff[i] <= R_W'(rnd16((WIDE_W'(vel2_ff[i]) <<< 16) - (WIDE_W'(ns_ff[i]) <<< 1)));
         end
      end
   end

   // stage 4: r*n
   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         for (int i = 0; i < 3; i++) begin
            rn_ff[i] <= r3_ff[i] * nrm[i];
            r4_ff[i] <= r3_ff[i];
         end
      end
   end

   // stage 5: t = r.n
   assign t_sum = WIDE_W'(rn_ff[0]) + WIDE_W'(rn_ff[1]) + WIDE_W'(rn_ff[2]);

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         t_ff <= T_W'(rnd16(t_sum));
         for (int i = 0; i < 3; i++) begin
            r5_ff[i] <= r4_ff[i];
         end
      end
   end

   // stage 6: n*t; carry r along
   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         for (int i = 0; i < 3; i++) begin
            nt_ff[i] <= nrm[i] * t_ff;
            r6_ff[i] <= r5_ff[i];
         end
      end
   end

   // stage 7: split, new position, small flags
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rv_c[i] = RV_W'(rnd16(WIDE_W'(nt_ff[i])));
         rh_c[i] = RH_W'(r6_ff[i]) - RH_W'(rv_c[i]);
         if (hit_pipe_ff[NSTG-2]) begin
            np_c[i] = sat32(WIDE_W'(pos_pipe_ff[NSTG-2][i]) + WIDE_W'(rv_c[i]));
         end else begin
            np_c[i] = pos_pipe_ff[NSTG-2][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         hit7_ff     <= hit_pipe_ff[NSTG-2];
         rv_small_ff <= is_small(RH_W'(rv_c[0]), RH_W'(rv_c[1]), RH_W'(rv_c[2]));
         rh_small_ff <= is_small(rh_c[0], rh_c[1], rh_c[2]);
         for (int i = 0; i < 3; i++) begin
            np_ff[i]    <= np_c[i];
            prev7_ff[i] <= prev_pipe_ff[NSTG-2][i];
            rv_ff[i]    <= rv_c[i];
            rh_ff[i]    <= rh_c[i];
         end
      end
   end

   assign hit_out      = hit7_ff;
   assign np_out       = np_ff;
   assign prev_out     = prev7_ff;
   assign rv_out       = rv_ff;
   assign rh_out       = rh_ff;
   assign rv_small_out = rv_small_ff;
   assign rh_small_out = rh_small_ff;

endmodule

@@ rtl/core/ppc_gain.sv @@
// ----------------------------------------------------------------------------
// ppc_gain: restitution/friction scaling and new previous position
// Stage 8 scales the kept parts by their gains; stage 9 rounds, forms the new
// previous position and holds the result beat.
// ----------------------------------------------------------------------------
module ppc_gain import ppc_pkg::*; (
   input  logic       clock,
   input  logic [1:0] stage_en,
   input  cfg_type    cfg,
   input  logic       hit_in,
   input  pos_type    np_in   [3],
   input  pos_type    prev_in [3],
   input  rv_type     rv_in   [3],
   input  rh_type     rh_in   [3],
   input  logic       rv_small,
   input  logic       rh_small,
   output logic       hit_out,
   output pos_type    new_pos_out  [3],
   output pos_type    new_prev_out [3]
);

   logic signed [GAIN_W:0] rest_s;
   logic signed [GAIN_W:0] fric_s;

   logic signed [RVG_W-1:0] rvg_ff [3];
   logic signed [RHG_W-1:0] rhg_ff [3];
   logic    hit8_ff;
   pos_type np8_ff   [3];
   pos_type prev8_ff [3];

   wide_type vel_c [3];
   pos_type  npr_c [3];

   logic    hit9_ff;
   pos_type pos9_ff  [3];
   pos_type prev9_ff [3];

   assign rest_s = $signed({1'b0, cfg.restitution_gain});
   assign fric_s = $signed({1'b0, cfg.friction_gain});

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         hit8_ff <= hit_in;
         for (int i = 0; i < 3; i++) begin
            rvg_ff[i]   <= rv_small ? RVG_W'(0) : rv_in[i] * rest_s;
            rhg_ff[i]   <= rh_small ? RHG_W'(0) : rh_in[i] * fric_s;
            np8_ff[i]   <= np_in[i];
            prev8_ff[i] <= prev_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vel_c[i] = rnd16(WIDE_W'(rvg_ff[i])) + rnd16(WIDE_W'(rhg_ff[i]));
         npr_c[i] = sat32(WIDE_W'(np8_ff[i]) - vel_c[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         hit9_ff <= hit8_ff;
         for (int i = 0; i < 3; i++) begin
            pos9_ff[i]  <= np8_ff[i];
            prev9_ff[i] <= hit8_ff ? npr_c[i] : prev8_ff[i];
         end
      end
   end

   assign hit_out      = hit9_ff;
   assign new_pos_out  = pos9_ff;
   assign new_prev_out = prev9_ff;

endmodule

@@ rtl/core/particle_plane_collision_unit.sv @@
// ----------------------------------------------------------------------------
// particle_plane_collision_unit: Verlet particle against a plane
// Ten-stage pipeline that detects a plane crossing and reflects the particle.
// ----------------------------------------------------------------------------
// One particle beat enters per cycle while the result is not stalled, and its
// result beat leaves from stage 9; the throughput of one beat per cycle is
// set by the ten register stages, each holding one multiply or a short chain
// of wide adds, compares and saturation.
// A beat hits when n.p < d and n.p_old >= d; then the velocity p - p_old is
// reflected about the normal, the normal part moves the position, and the
// parts scaled by restitution and friction give the new previous position.
// Parts with squared length at most 0.0001 are dropped. Without a hit both
// positions pass unchanged. Outputs saturate to Q16.16. Bubbles collapse,
// so a stalled result does not block new beats until every stage is full.
// Write the csr registers only while no beat is in flight.
// ----------------------------------------------------------------------------
module particle_plane_collision_unit import ppc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // input beats
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [31:0]    req_pos_x,
   input  logic signed [31:0]    req_pos_y,
   input  logic signed [31:0]    req_pos_z,
   input  logic signed [31:0]    req_prev_x,
   input  logic signed [31:0]    req_prev_y,
   input  logic signed [31:0]    req_prev_z,
   // result beats
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_new_pos_x,
   output logic signed [31:0]    rsp_new_pos_y,
   output logic signed [31:0]    rsp_new_pos_z,
   output logic signed [31:0]    rsp_new_prev_x,
   output logic signed [31:0]    rsp_new_prev_y,
   output logic signed [31:0]    rsp_new_prev_z,
   output logic                  rsp_hit,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff;

   logic [NUM_STAGES-1:0] stage_en;

   pos_type pos_in  [3];
   pos_type prev_in [3];

   logic    pt_hit;
   s_type   pt_s;
   pos_type pt_pos  [3];
   pos_type pt_prev [3];
   vel_type pt_vel  [3];

   logic    rf_hit;
   pos_type rf_np   [3];
   pos_type rf_prev [3];
   rv_type  rf_rv   [3];
   rh_type  rf_rh   [3];
   logic    rf_rv_small;
   logic    rf_rh_small;

   pos_type out_pos  [3];
   pos_type out_prev [3];

   // register file: take a write in any cycle, ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_x         <= '0;
         cfg_ff.normal_y         <= NRM_W'(65536);
         cfg_ff.normal_z         <= '0;
         cfg_ff.plane_offset     <= '0;
         cfg_ff.friction_gain    <= GAIN_W'(65536);
         cfg_ff.restitution_gain <= GAIN_W'(65536);
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_NORMAL_X: begin
               cfg_ff.normal_x <= csr_wdata[NRM_W-1:0];
            end
            CSR_NORMAL_Y: begin
               cfg_ff.normal_y <= csr_wdata[NRM_W-1:0];
            end
            CSR_NORMAL_Z: begin
               cfg_ff.normal_z <= csr_wdata[NRM_W-1:0];
            end
            CSR_PLANE_OFFSET: begin
               cfg_ff.plane_offset <= csr_wdata[POS_W-1:0];
            end
            CSR_FRICTION: begin
               cfg_ff.friction_gain <= csr_wdata[GAIN_W-1:0];
            end
            CSR_RESTITUTION: begin
               cfg_ff.restitution_gain <= csr_wdata[GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // valid bits and stage load enables
   ppc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_ready (rsp_ready),
      .stage_en  (stage_en),
      .out_valid (rsp_valid)
   );

   assign req_ready = stage_en[0];

   assign pos_in[0]  = req_pos_x;
   assign pos_in[1]  = req_pos_y;
   assign pos_in[2]  = req_pos_z;
   assign prev_in[0] = req_prev_x;
   assign prev_in[1] = req_prev_y;
   assign prev_in[2] = req_prev_z;

   // stages 0..1: crossing test and s = v.n
   ppc_plane_test u_test (
      .clock    (clock),
      .stage_en (stage_en[1:0]),
      .cfg      (cfg_ff),
      .pos_in   (pos_in),
      .prev_in  (prev_in),
      .hit_out  (pt_hit),
      .s_out    (pt_s),
      .pos_out  (pt_pos),
      .prev_out (pt_prev),
      .vel_out  (pt_vel)
   );

   // stages 2..7: reflection, split, new position
   ppc_reflect u_refl (
      .clock        (clock),
      .stage_en     (stage_en[7:2]),
      .cfg          (cfg_ff),
      .hit_in       (pt_hit),
      .s_in         (pt_s),
      .pos_in       (pt_pos),
      .prev_in      (pt_prev),
      .vel_in       (pt_vel),
      .hit_out      (rf_hit),
      .np_out       (rf_np),
      .prev_out     (rf_prev),
      .rv_out       (rf_rv),
      .rh_out       (rf_rh),
      .rv_small_out (rf_rv_small),
      .rh_small_out (rf_rh_small)
   );

   // stages 8..9: gains and output register
   ppc_gain u_gain (
      .clock        (clock),
      .stage_en     (stage_en[9:8]),
      .cfg          (cfg_ff),
      .hit_in       (rf_hit),
      .np_in        (rf_np),
      .prev_in      (rf_prev),
      .rv_in        (rf_rv),
      .rh_in        (rf_rh),
      .rv_small     (rf_rv_small),
      .rh_small     (rf_rh_small),
      .hit_out      (rsp_hit),
      .new_pos_out  (out_pos),
      .new_prev_out (out_prev)
   );

   assign rsp_new_pos_x  = out_pos[0];
   assign rsp_new_pos_y  = out_pos[1];
   assign rsp_new_pos_z  = out_pos[2];
   assign rsp_new_prev_x = out_prev[0];
   assign rsp_new_prev_y = out_prev[1];
   assign rsp_new_prev_z = out_prev[2];

endmodule
